@@ hw/rtl/mm3_pkg.sv @@
`timescale 1ns / 1ps

package mm3_pkg;

    localparam logic [63:0] C_ONE   = 64'h87c37b91114253d5;
    localparam logic [63:0] C_TWO   = 64'h4cf5ad432745937f;
    localparam logic [63:0] ADD_ONE = 64'h0000000052dce729;
    localparam logic [63:0] ADD_TWO = 64'h0000000038495ab5;
    localparam logic [63:0] FM_ONE  = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FM_TWO  = 64'hc4ceb9fe1a85ec53;

    localparam int MUL_STEPS = 4;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_K1_M1, ST_K1_M2, ST_K2_M1, ST_K2_M2,
        ST_H1_MIX, ST_H2_MIX,
        ST_FIN_ADD,
        ST_A_X1, ST_A_M1, ST_A_X2, ST_A_M2, ST_A_X3,
        ST_B_X1, ST_B_M1, ST_B_X2, ST_B_M2, ST_B_X3,
        ST_FIN_OUT,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] prod;
    } mul_rsp_t;

    function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] r);
        rotl = (x << r) | (x >> (7'd64 - {1'b0, r}));
    endfunction

    function automatic logic [63:0] byte_mask(input logic [4:0] n);
        logic [63:0] m;
        m = '1;
        if (n < 5'd8) begin
            m = (64'd1 << {n[2:0], 3'b000}) - 64'd1;
        end
        byte_mask = m;
    endfunction

endpackage

@@ hw/rtl/mm3_mul.sv @@
`timescale 1ns / 1ps

module mm3_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  mm3_pkg::mul_req_t req,
    output mm3_pkg::mul_rsp_t rsp
);
    import mm3_pkg::*;

    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] part;

    // 64x16 partial product per cycle, low 64 bits kept
    assign part = a_reg * {48'd0, b_reg[15:0]};

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next  = acc_reg + part;
            a_next    = a_reg << 16;
            b_next    = b_reg >> 16;
            step_next = step_reg + 2'd1;
            if (step_reg == 2'(MUL_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;
endmodule

@@ hw/rtl/murmur3_x64_128_hash.sv @@
`timescale 1ns / 1ps

// MurmurHash3 x64_128 engine. Feed a message as 16-byte blocks; assert tlast on the final
// block with its valid byte count (0..16, above 16 treated as 16). One 64-bit multiplier,
// built as four 64x16 steps, is shared by every multiply, and the sequencer waits on each
// multiply. A block is taken only once the one before it is fully mixed; a last block with
// 0 bytes skips the block multiplies and goes straight to finalization, and any last block's
// hash may also wait for room on the m_ side. A hash is held in the output
// register until taken; the next message can be fed meanwhile, but its own hash waits until
// that register frees up. Writing the seed reloads both lanes and clears the length,
// abandoning any message in progress.
module murmur3_x64_128_hash (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // block_lo[63:0], block_hi[127:64], byte_count[132:128]
    input  logic         s_tlast,   // last
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // hash_lo[63:0], hash_hi[127:64]
);
    import mm3_pkg::*;

    state_t      state_reg, state_next;
    logic [63:0] seed_reg, seed_next;
    logic [63:0] h1_reg, h1_next;
    logic [63:0] h2_reg, h2_next;
    logic [63:0] len_reg, len_next;
    logic [63:0] k1_reg, k1_next;
    logic [63:0] k2_reg, k2_next;
    logic [4:0]  n_reg, n_next;
    logic        last_reg, last_next;
    logic [127:0] out_reg, out_next;
    logic        out_valid_reg, out_valid_next;
    logic        wait_reg, wait_next;
    mul_req_t    req;
    mul_rsp_t    rsp;
    logic [4:0]  n_in;
    logic [63:0] t;

    mm3_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(req), .rsp(rsp));

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;
    assign n_in      = (s_tdata[132:128] > 5'd16) ? 5'd16 : s_tdata[132:128];

    always_comb begin
        state_next     = state_reg;
        seed_next      = seed_reg;
        h1_next        = h1_reg;
        h2_next        = h2_reg;
        len_next       = len_reg;
        k1_next        = k1_reg;
        k2_next        = k2_reg;
        n_next         = n_reg;
        last_next      = last_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        wait_next      = 1'b0;
        req.start      = 1'b0;
        req.a          = '0;
        req.b          = '0;
        t              = '0;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (cfg_valid) begin
                    seed_next = {32'd0, cfg_data};
                    h1_next   = {32'd0, cfg_data};
                    h2_next   = {32'd0, cfg_data};
                    len_next  = '0;
                end else if (s_tvalid) begin
                    last_next = s_tlast;
                    n_next    = s_tlast ? n_in : 5'd16;
                    if (s_tlast && n_in != 5'd16) begin
                        k1_next = s_tdata[63:0] & byte_mask(n_in);
                        k2_next = s_tdata[127:64] &
                                  ((n_in > 5'd8) ? byte_mask(n_in - 5'd8) : 64'd0);
                    end else begin
                        k1_next = s_tdata[63:0];
                        k2_next = s_tdata[127:64];
                    end
                    len_next = len_reg + (s_tlast ? {59'd0, n_in} : 64'd16);
                    if (s_tlast && n_in == 5'd0) begin
                        state_next = ST_FIN_ADD;
                    end else begin
                        state_next = ST_K1_M1;
                        wait_next  = 1'b1;
                    end
                end
            end
            ST_K1_M1: begin
                req.start = wait_reg;
                req.a = k1_reg;
                req.b = C_ONE;
                if (rsp.done) begin
                    k1_next    = rotl(rsp.prod, 6'd31);
                    state_next = ST_K1_M2;
                    wait_next  = 1'b1;
                end
            end
            ST_K1_M2: begin
                req.start = wait_reg;
                req.a = k1_reg;
                req.b = C_TWO;
                if (rsp.done) begin
                    k1_next    = rsp.prod;
                    state_next = ST_K2_M1;
                    wait_next  = 1'b1;
                end
            end
            ST_K2_M1: begin
                req.start = wait_reg;
                req.a = k2_reg;
                req.b = C_TWO;
                if (rsp.done) begin
                    k2_next    = rotl(rsp.prod, 6'd33);
                    state_next = ST_K2_M2;
                    wait_next  = 1'b1;
                end
            end
            ST_K2_M2: begin
                req.start = wait_reg;
                req.a = k2_reg;
                req.b = C_ONE;
                if (rsp.done) begin
                    k2_next = rsp.prod;
                    if (n_reg == 5'd16) begin
                        state_next = ST_H1_MIX;
                    end else begin
                        h1_next = h1_reg ^ k1_reg;
                        state_next = ST_FIN_ADD;
                    end
                end
            end
            ST_H1_MIX: begin
                t = rotl(h1_reg ^ k1_reg, 6'd27) + h2_reg;
                h1_next = (t << 2) + t + ADD_ONE;
                state_next = ST_H2_MIX;
            end
            ST_H2_MIX: begin
                t = rotl(h2_reg ^ k2_reg, 6'd31) + h1_reg;
                h2_next = (t << 2) + t + ADD_TWO;
                state_next = last_reg ? ST_FIN_ADD : ST_IDLE;
            end
            ST_FIN_ADD: begin
                // tail case: lane two mixed with k2 (zero mask leaves k2 at 0 -> skip)
                if (n_reg != 5'd16 && n_reg > 5'd8) begin
                    t = h2_reg ^ k2_reg;
                end else begin
                    t = h2_reg;
                end
                // k1 for tail already folded into h1 at ST_K2_M2
                k1_next = (h1_reg ^ len_reg) + (t ^ len_reg);
                k2_next = (t ^ len_reg) + (h1_reg ^ len_reg) + (t ^ len_reg);
                state_next = ST_A_X1;
            end
            ST_A_X1: begin
                k1_next = k1_reg ^ (k1_reg >> 33);
                state_next = ST_A_M1;
                wait_next = 1'b1;
            end
            ST_A_M1: begin
                req.start = wait_reg;
                req.a = k1_reg;
                req.b = FM_ONE;
                if (rsp.done) begin
                    k1_next = rsp.prod;
                    state_next = ST_A_X2;
                end
            end
            ST_A_X2: begin
                k1_next = k1_reg ^ (k1_reg >> 33);
                state_next = ST_A_M2;
                wait_next = 1'b1;
            end
            ST_A_M2: begin
                req.start = wait_reg;
                req.a = k1_reg;
                req.b = FM_TWO;
                if (rsp.done) begin
                    k1_next = rsp.prod;
                    state_next = ST_A_X3;
                end
            end
            ST_A_X3: begin
                k1_next = k1_reg ^ (k1_reg >> 33);
                k2_next = k2_reg ^ (k2_reg >> 33);
                state_next = ST_B_M1;
                wait_next = 1'b1;
            end
            ST_B_X1: begin
                k2_next = k2_reg ^ (k2_reg >> 33);
                state_next = ST_B_M1;
                wait_next = 1'b1;
            end
            ST_B_M1: begin
                req.start = wait_reg;
                req.a = k2_reg;
                req.b = FM_ONE;
                if (rsp.done) begin
                    k2_next = rsp.prod;
                    state_next = ST_B_X2;
                end
            end
            ST_B_X2: begin
                k2_next = k2_reg ^ (k2_reg >> 33);
                state_next = ST_B_M2;
                wait_next = 1'b1;
            end
            ST_B_M2: begin
                req.start = wait_reg;
                req.a = k2_reg;
                req.b = FM_TWO;
                if (rsp.done) begin
                    k2_next = rsp.prod;
                    state_next = ST_B_X3;
                end
            end
            ST_B_X3: begin
                k2_next = k2_reg ^ (k2_reg >> 33);
                state_next = ST_FIN_OUT;
            end
            ST_FIN_OUT: begin
                state_next = ST_HOLD;
                if (!out_valid_next) begin
                    out_next = {k2_reg + k1_reg + k2_reg, k1_reg + k2_reg};
                    out_valid_next = 1'b1;
                    h1_next = seed_reg;
                    h2_next = seed_reg;
                    len_next = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_HOLD: begin
                state_next = ST_FIN_OUT;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            wait_reg      <= 1'b0;
            seed_reg      <= '0;
            h1_reg        <= '0;
            h2_reg        <= '0;
            len_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            wait_reg      <= wait_next;
            seed_reg      <= seed_next;
            h1_reg        <= h1_next;
            h2_reg        <= h2_next;
            len_reg       <= len_next;
        end
        k1_reg   <= k1_next;
        k2_reg   <= k2_next;
        n_reg    <= n_next;
        last_reg <= last_next;
        out_reg  <= out_next;
    end
endmodule
